@@ sv/bdm_pkg.sv @@
// Shared types and constants for the 2x2 Bayer demosaic block.
`default_nettype none

package bdm_pkg;

  // Payload widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned FWIDTH_W = 13;

  // Configuration port shape
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = FWIDTH_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PATTERN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd1;

  // Reset values and defaults
  localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST = 13'd640;
  localparam int unsigned         MAX_WIDTH_DEF   = 4096;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Colour filter arrangement selected by software
  typedef enum logic [1:0] {
    PAT_RGGB = 2'd0,
    PAT_GBRG = 2'd1,
    PAT_BGGR = 2'd2,
    PAT_NONE = 2'd3
  } pattern_e;

  // Site of red within the window: 0 upper-left, 1 upper-right,
  // 2 lower-left, 3 lower-right
  typedef enum logic [1:0] {
    RED_UL = 2'd0,
    RED_UR = 2'd1,
    RED_LL = 2'd2,
    RED_LR = 2'd3
  } red_site_e;

endpackage

`default_nettype wire

@@ sv/bdm_pix_if.sv @@
// Raw pixel channel: valid/ready handshake with one Bayer sample per beat.
`default_nettype none

interface bdm_pix_if;
  import bdm_pkg::*;

  logic valid;
  logic ready;
  pix_t raw_pixel;
  logic frame_start;

  modport source (output valid, raw_pixel, frame_start, input ready);
  modport sink   (input valid, raw_pixel, frame_start, output ready);
endinterface

`default_nettype wire

@@ sv/bdm_rgb_if.sv @@
// RGB result channel: valid/ready handshake with one coloured pixel per beat.
`default_nettype none

interface bdm_rgb_if;
  import bdm_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_row;
  coord_t out_col;
  pix_t   red;
  pix_t   green;
  pix_t   blue;

  modport source (output valid, out_row, out_col, red, green, blue, input ready);
  modport sink   (input valid, out_row, out_col, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ sv/bdm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/bayer_demosaic_2x2_window.sv @@
// Top level of the streaming 2x2 nearest-neighbour Bayer demosaic.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------
//   pix_i    | in  | valid/ready  | raw_pixel[7:0], frame_start
//   rgb_o    | out | valid/ready  | out_row[11:0], out_col[11:0], red, green, blue
//   cfg      | in  | cfg_we_i     | cfg_idx_i (register), cfg_wdata_i[12:0]
//
// One raw pixel is taken every cycle; its result (if any) passes the window stage
// and then the output register. The line store read is issued in the accept cycle
// and the window is resolved in the following cycle from its registered data.
// Reset clears counters, window registers and configuration; the line store
// is not cleared and needs no start-up pass.
// Backpressure on rgb_o stalls the window stage, which then drops pix_i.ready.
`default_nettype none

module bayer_demosaic_2x2_window #(
  parameter int unsigned MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bdm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bdm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  bdm_pix_if.sink                               pix_i,
  bdm_rgb_if.source                             rgb_o
);
  import bdm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (AW + 1 > FWIDTH_W) ? AW + 1 : FWIDTH_W;

  // Configuration
  pattern_e            pattern_q;
  logic [FWIDTH_W-1:0] fw_q;

  // Position counters
  logic [AW-1:0] col_q;
  coord_t        row_q;

  // Window stage
  logic          s1_v_q;
  pix_t          s1_px_q;
  logic [AW-1:0] s1_col_q;
  logic          s1_prod_q;
  coord_t        s1_row_q;
  coord_t        s1_ocol_q;
  red_site_e     s1_site_q;
  logic          fwd_q;
  pix_t          fwd_px_q;
  pix_t          ul_q;
  pix_t          ll_q;

  // Output register
  logic   out_v_q;
  coord_t out_row_q;
  coord_t out_col_q;
  pix_t   red_q;
  pix_t   green_q;
  pix_t   blue_q;

  logic [EW-1:0] fw_x;
  logic [EW-1:0] width_w;
  logic          in_fire;
  logic          s1_adv;
  logic [AW-1:0] acc_col;
  coord_t        acc_row;
  logic [EW-1:0] col_inc;
  logic          row_last;
  logic [AW-1:0] col_m1;
  logic [1:0]    flip;
  red_site_e     acc_site;
  pix_t          ram_rdata;
  pix_t          above;
  logic [PIX_W:0] sum_diag;
  logic [PIX_W:0] sum_anti;
  pix_t          red_d;
  pix_t          green_d;
  pix_t          blue_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PAT_RGGB;
      fw_q      <= FRAME_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_PATTERN: pattern_q <= pattern_e'(cfg_wdata_i[1:0]);
        CFG_FRAME_WIDTH:  fw_q      <= cfg_wdata_i[FWIDTH_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamp the programmed width to the supported range
  assign fw_x    = EW'(fw_q);
  assign width_w = (fw_x < EW'(2))         ? EW'(2) :
                   (fw_x > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw_x;

  // Handshake
  assign s1_adv      = s1_v_q && (!out_v_q || rgb_o.ready);
  assign pix_i.ready = !s1_v_q || s1_adv;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // Position of the incoming beat
  always_comb begin
    if (pix_i.frame_start || (EW'(col_q) >= width_w)) begin
      acc_col = '0;
    end else begin
      acc_col = col_q;
    end
    acc_row  = pix_i.frame_start ? '0 : row_q;
    col_inc  = EW'(acc_col) + EW'(1);
    row_last = col_inc >= width_w;
    col_m1   = acc_col - AW'(1);
  end

  // Red site from pattern and parity of the window's upper-left corner
  always_comb begin
    case (pattern_q)
      PAT_RGGB: flip = 2'd0;
      PAT_GBRG: flip = 2'd2;
      PAT_BGGR: flip = 2'd3;
      default:  flip = 2'd0;
    endcase
    if (pattern_q == PAT_NONE) begin
      acc_site = RED_UL;
    end else begin
      acc_site = red_site_e'({~acc_row[0], ~acc_col[0]} ^ flip);
    end
  end

  // Advance the position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (row_last) begin
        col_q <= '0;
        row_q <= acc_row + COORD_W'(1);
      end else begin
        col_q <= AW'(col_inc);
        row_q <= acc_row;
      end
    end
  end

  // Previous line, read at accept, written as the window stage retires
  bdm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_fire),
    .raddr_i (acc_col),
    .rdata_o (ram_rdata)
  );

  // Load the window stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q   <= pix_i.raw_pixel;
      s1_col_q  <= acc_col;
      s1_prod_q <= (acc_row != '0) && (acc_col != '0);
      s1_row_q  <= acc_row - COORD_W'(1);
      s1_ocol_q <= COORD_W'(col_m1);
      s1_site_q <= acc_site;
      // Forward the sample being written when the read hits the same entry
      fwd_q     <= s1_adv && (s1_col_q == acc_col);
      fwd_px_q  <= s1_px_q;
    end
  end

  assign above = fwd_q ? fwd_px_q : ram_rdata;

  // Hold the left column of the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q <= '0;
      ll_q <= '0;
    end else if (s1_adv) begin
      ul_q <= above;
      ll_q <= s1_px_q;
    end
  end

  // Resolve the window: ul_q above-left, above upper-right,
  // ll_q lower-left, s1_px_q lower-right
  assign sum_diag = {1'b0, ul_q} + {1'b0, s1_px_q};
  assign sum_anti = {1'b0, above} + {1'b0, ll_q};

  always_comb begin
    case (s1_site_q)
      RED_UL: begin
        red_d   = ul_q;
        green_d = sum_anti[PIX_W:1];
        blue_d  = s1_px_q;
      end
      RED_UR: begin
        red_d   = above;
        green_d = sum_diag[PIX_W:1];
        blue_d  = ll_q;
      end
      RED_LL: begin
        red_d   = ll_q;
        green_d = sum_diag[PIX_W:1];
        blue_d  = above;
      end
      RED_LR: begin
        red_d   = s1_px_q;
        green_d = sum_anti[PIX_W:1];
        blue_d  = ul_q;
      end
      default: begin
        red_d   = ul_q;
        green_d = sum_anti[PIX_W:1];
        blue_d  = s1_px_q;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= s1_prod_q;
    end else if (rgb_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_prod_q) begin
      out_row_q <= s1_row_q;
      out_col_q <= s1_ocol_q;
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
    end
  end

  assign rgb_o.valid   = out_v_q;
  assign rgb_o.out_row = out_row_q;
  assign rgb_o.out_col = out_col_q;
  assign rgb_o.red     = red_q;
  assign rgb_o.green   = green_q;
  assign rgb_o.blue    = blue_q;

endmodule

`default_nettype wire

@@ sv/bdm_chk.sv @@
// Port-level checks for the Bayer demosaic block, bound to its top level.
`default_nettype none

module bdm_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  in_frame_start_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire bdm_pkg::coord_t       out_row_i,
  input wire bdm_pkg::coord_t       out_col_i,
  input wire bdm_pkg::pix_t         red_i,
  input wire bdm_pkg::pix_t         green_i,
  input wire bdm_pkg::pix_t         blue_i
);
  import bdm_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_col_i) &&
      $stable(red_i) && $stable(green_i) && $stable(blue_i))
    else $error("result payload changed while stalled");

  // Input is refused only when a result is backed up
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input refused without a pending result");

  // A fresh result rises only after an accepted beat that is not a frame start
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && !in_frame_start_i, 2))
    else $error("result raised without a matching input beat");

endmodule

bind bayer_demosaic_2x2_window bdm_chk u_bdm_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (pix_i.valid),
  .in_ready_i       (pix_i.ready),
  .in_frame_start_i (pix_i.frame_start),
  .out_valid_i      (rgb_o.valid),
  .out_ready_i      (rgb_o.ready),
  .out_row_i        (rgb_o.out_row),
  .out_col_i        (rgb_o.out_col),
  .red_i            (rgb_o.red),
  .green_i          (rgb_o.green),
  .blue_i           (rgb_o.blue)
);

`default_nettype wire

@@ tb/tb_bayer_demosaic_2x2_window.sv @@
// Self-checking testbench for the streaming 2x2 Bayer demosaic block.
module tb_bayer_demosaic_2x2_window;
  timeunit 1ns;
  timeprecision 1ps;

  import bdm_pkg::*;

  localparam int unsigned CLK_HALF_NS    = 5;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam longint     RUN_LIMIT_NS   = 5_000_000;

  // Directed frames: a 3x3 RGGB frame, a restarted 2-wide frame, a continuation
  localparam pix_t CORNER_GRID [9] = '{8'h00, 8'hFF, 8'hFF,
                                       8'hFF, 8'hFF, 8'h00,
                                       8'h01, 8'h80, 8'h7F};
  localparam pix_t RESTART_SEQ [8] = '{8'h80, 8'h01, 8'hFE, 8'h7F,
                                       8'h55, 8'hAA, 8'h33, 8'hCC};
  localparam pix_t CONTINUE_SEQ [4] = '{8'hE0, 8'h1F, 8'h0F, 8'hF0};

  typedef struct packed {
    logic fs;
    pix_t raw;
  } raw_beat_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
    pix_t   red;
    pix_t   green;
    pix_t   blue;
  } rgb_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bdm_pix_if pix_if ();
  bdm_rgb_if rgb_if ();

  bayer_demosaic_2x2_window dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if.sink),
    .rgb_o       (rgb_if.source)
  );

  // Stimulus and expectation stores
  raw_beat_t raw_pending [$];
  rgb_beat_t rgb_pending [$];

  // Shadow of the block: configuration, line memory, window and position
  pattern_e      cur_pattern;
  logic [12:0]   cur_width;
  pix_t          line_mem [MAX_WIDTH_DEF];
  pix_t          ul_pix;
  pix_t          ll_pix;
  coord_t        row_pos;
  coord_t        col_pos;

  // Run control and bookkeeping
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rx_hold_left;
  bit          rx_hold_arm;
  bit          pix_beat_done;
  int unsigned mismatch_count;
  int unsigned random_beats;
  int unsigned raw_beats_in;
  int unsigned frame_starts;
  int unsigned rgb_beats_out;
  int unsigned reg_writes;

  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  // Clamp a programmed width to what the block can hold
  function automatic int unsigned active_cols(input logic [12:0] w);
    if (w < 2) return 2;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic pix_t mean_floor(input pix_t a, input pix_t b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8:1];
  endfunction

  // Advance the shadow by one raw beat and queue the RGB beat it completes
  function automatic void demosaic_window(input pix_t px, input logic fs);
    int unsigned w;
    coord_t      c;
    pix_t        above;
    red_site_e   origin;
    red_site_e   site;
    rgb_beat_t   res;
    w = active_cols(cur_width);
    if (fs) begin
      row_pos = '0;
      col_pos = '0;
    end
    if (col_pos >= w) col_pos = '0;
    c     = col_pos;
    above = line_mem[c];
    if (row_pos >= 1 && c >= 1) begin
      res.row = row_pos - 1'b1;
      res.col = c - 1'b1;
      // Red site at the pattern's even/even origin, moved by row/col parity
      case (cur_pattern)
        PAT_GBRG: origin = RED_LL;
        PAT_BGGR: origin = RED_LR;
        default:  origin = RED_UL;
      endcase
      if (cur_pattern == PAT_NONE) site = RED_UL;
      else site = red_site_e'({res.row[0], res.col[0]} ^ origin);
      case (site)
        RED_UL: begin
          res.red = ul_pix; res.green = mean_floor(above, ll_pix); res.blue = px;
        end
        RED_UR: begin
          res.red = above; res.green = mean_floor(ul_pix, px); res.blue = ll_pix;
        end
        RED_LL: begin
          res.red = ll_pix; res.green = mean_floor(ul_pix, px); res.blue = above;
        end
        default: begin
          res.red = px; res.green = mean_floor(above, ll_pix); res.blue = ul_pix;
        end
      endcase
      rgb_pending.push_back(res);
    end
    ul_pix      = above;
    ll_pix      = px;
    line_mem[c] = px;
    if (int'(c) + 1 >= w) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = c + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Drive the raw channel: hold a beat until taken, then maybe idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_beat_done) begin
      if (raw_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pix_if.valid       <= 1'b1;
        pix_if.raw_pixel   <= raw_pending[0].raw;
        pix_if.frame_start <= raw_pending[0].fs;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Count down a long receiver hold once armed
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
    else if (rx_hold_arm) rx_hold_left <= RX_HOLD_CYCLES;
  end

  // Drive ready on the RGB channel
  always @(negedge clk_i) begin
    rgb_if.ready <= rst_ni && rx_hold_left == 0 && $urandom_range(0, 99) >= recv_idle_pct;
  end

  // Predict on every accepted raw beat, check every accepted RGB beat
  always @(posedge clk_i) begin
    rgb_beat_t seen;
    rgb_beat_t want;
    if (rst_ni) begin
      pix_beat_done = pix_if.valid && pix_if.ready;
      if (pix_beat_done) begin
        demosaic_window(pix_if.raw_pixel, pix_if.frame_start);
        void'(raw_pending.pop_front());
        raw_beats_in++;
      end
      if (rgb_if.valid && rgb_if.ready) begin
        seen = '{rgb_if.out_row, rgb_if.out_col, rgb_if.red, rgb_if.green, rgb_if.blue};
        if (rgb_pending.size() == 0) begin
          report_mismatch($sformatf("unexpected RGB beat row %0d col %0d",
                                    seen.row, seen.col));
        end else begin
          want = rgb_pending.pop_front();
          if (seen.row !== want.row)
            report_mismatch($sformatf("out_row got %0d want %0d", seen.row, want.row));
          if (seen.col !== want.col)
            report_mismatch($sformatf("out_col got %0d want %0d (row %0d)",
                                      seen.col, want.col, want.row));
          if (seen.red !== want.red)
            report_mismatch($sformatf("red got %0h want %0h at (%0d,%0d)",
                                      seen.red, want.red, want.row, want.col));
          if (seen.green !== want.green)
            report_mismatch($sformatf("green got %0h want %0h at (%0d,%0d)",
                                      seen.green, want.green, want.row, want.col));
          if (seen.blue !== want.blue)
            report_mismatch($sformatf("blue got %0h want %0h at (%0d,%0d)",
                                      seen.blue, want.blue, want.row, want.col));
          rgb_beats_out++;
        end
      end
    end
  end

  task automatic queue_pixel(input pix_t px, input logic fs);
    raw_pending.push_back('{fs, px});
    if (fs) frame_starts++;
  endtask

  task automatic wait_all_done();
    while (raw_pending.size() != 0 || rgb_pending.size() != 0) @(posedge clk_i);
  endtask

  // Let the pipeline drain fully before touching configuration
  task automatic settle_idle();
    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASE_PATTERN: cur_pattern = pattern_e'(val[1:0]);
      CFG_FRAME_WIDTH:  cur_width   = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Plain raster stream with an optional frame start on the first beat
  task automatic queue_stream(input int unsigned count, input logic first_fs);
    for (int unsigned i = 0; i < count; i++)
      queue_pixel(pix_t'($urandom_range(0, 255)), first_fs && i == 0);
  endtask

  // Mostly whole frames of random height, a few frames cut short or left unmarked
  task automatic queue_random_frames(input int unsigned count, input logic start_frame);
    int unsigned w;
    int unsigned left;
    logic        fs;
    w    = active_cols(cur_width);
    left = start_frame ? 0 : w * 2;
    for (int unsigned i = 0; i < count; i++) begin
      fs = 1'b0;
      if (left == 0) begin
        left = w * $urandom_range(2, 6);
        fs   = start_frame && i == 0 || $urandom_range(0, 99) < 85;
      end else if ($urandom_range(0, 99) < 2) begin
        left = w * $urandom_range(2, 6);
        fs   = 1'b1;
      end
      queue_pixel(pix_t'($urandom_range(0, 255)), fs);
      left--;
      random_beats++;
    end
  endtask

  // New pattern and width, then a burst that may continue the current frame
  task automatic run_random_phase(input int unsigned count);
    logic [12:0] w;
    settle_idle();
    case ($urandom_range(0, 9))
      0:       w = 13'($urandom_range(0, 1));
      1, 2:    w = 13'($urandom_range(13, 48));
      default: w = 13'($urandom_range(2, 12));
    endcase
    write_reg(CFG_BASE_PATTERN, CFG_DATA_W'(pattern_e'($urandom_range(PAT_RGGB, PAT_NONE))));
    write_reg(CFG_FRAME_WIDTH, w);
    queue_random_frames(count, $urandom_range(0, 99) < 75);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_BASE_PATTERN;
    cfg_wdata_i        = '0;
    pix_if.valid       = 1'b0;
    pix_if.raw_pixel   = '0;
    pix_if.frame_start = 1'b0;
    rgb_if.ready       = 1'b0;
    cur_pattern        = PAT_RGGB;
    cur_width          = FRAME_WIDTH_RST;
    ul_pix             = '0;
    ll_pix             = '0;
    row_pos            = '0;
    col_pos            = '0;
    send_idle_pct      = 14;
    recv_idle_pct      = 73;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: saturated and zero samples on all four window arrangements
    write_reg(CFG_BASE_PATTERN, CFG_DATA_W'(PAT_RGGB));
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    foreach (CORNER_GRID[i]) queue_pixel(CORNER_GRID[i], i == 0);

    // Directed: width below range, fallback mapping, restart in mid-frame
    settle_idle();
    write_reg(CFG_BASE_PATTERN, CFG_DATA_W'(PAT_NONE));
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    foreach (RESTART_SEQ[i]) queue_pixel(RESTART_SEQ[i], i == 0 || i == 4);

    // Directed: width one, counters carry on with no frame start
    settle_idle();
    write_reg(CFG_BASE_PATTERN, CFG_DATA_W'(PAT_GBRG));
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    foreach (CONTINUE_SEQ[i]) queue_pixel(CONTINUE_SEQ[i], 1'b0);

    // Fill the line store at the widest random width, then top of range in the same frame
    settle_idle();
    write_reg(CFG_BASE_PATTERN, CFG_DATA_W'(PAT_BGGR));
    write_reg(CFG_FRAME_WIDTH, 13'd48);
    queue_stream(100, 1'b1);
    settle_idle();
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    queue_stream(40, 1'b0);

    // Slow receiver
    while (random_beats < 330) run_random_phase($urandom_range(30, 110));

    // Slow sender, one long receiver hold and one sender pause
    send_idle_pct = 73;
    recv_idle_pct = 14;
    run_random_phase(150);
    @(posedge clk_i);
    rx_hold_arm = 1'b1;
    wait (rx_hold_left != 0);
    rx_hold_arm = 1'b0;
    wait_all_done();
    queue_random_frames(80, 1'b0);
    while (random_beats < 660) run_random_phase($urandom_range(30, 110));

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (random_beats < 960) run_random_phase($urandom_range(30, 110));

    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d RGB beats from %0d raw beats (%0d frame starts), %0d register writes;",
             rgb_beats_out, raw_beats_in, frame_starts, reg_writes);
    $display("all colour patterns, widths clamped at both ends, cut-short and unmarked frames.");
    if (mismatch_count == 0 && rgb_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: %0d raw beats left, %0d RGB beats outstanding",
             raw_pending.size(), rgb_pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
sv/bdm_pkg.sv
sv/bdm_pix_if.sv
sv/bdm_rgb_if.sv
sv/bdm_ram.sv
sv/bayer_demosaic_2x2_window.sv
sv/bdm_chk.sv
tb/tb_bayer_demosaic_2x2_window.sv
